[hdl/cchg_pkg.sv]
// Shared types and constants for the core-count hotplug governor.
package cchg_pkg;

    // Field widths.
    localparam int LoadW   = 16;
    localparam int EmaW    = 18;
    localparam int CountW  = 3;
    localparam int LimitW  = 10;
    localparam int HystW   = 4;
    localparam int MaskW   = 4;
    localparam int AddrW   = 5;
    localparam int DataW   = 32;

    // Exponential average weights, Q11.
    localparam logic [10:0] EmaKeep = 11'd1677;
    localparam logic [8:0]  EmaNew  = 9'd371;
    localparam int QShift     = 11;
    localparam int LimitShift = 8;

    // Register reset values.
    localparam logic [LimitW-1:0] LevelOneReset   = 10'd10;
    localparam logic [LimitW-1:0] LevelTwoReset   = 10'd18;
    localparam logic [LimitW-1:0] LevelThreeReset = 10'd20;
    localparam logic [HystW-1:0]  HystReset       = 4'd4;
    localparam logic [CountW-1:0] MinCoresReset   = 3'd1;
    localparam logic [CountW-1:0] MaxCoresReset   = 3'd4;

    // Register indexes.
    localparam logic [2:0] RegEnable     = 3'd0;
    localparam logic [2:0] RegMinCores   = 3'd1;
    localparam logic [2:0] RegMaxCores   = 3'd2;
    localparam logic [2:0] RegLevelOne   = 3'd3;
    localparam logic [2:0] RegLevelTwo   = 3'd4;
    localparam logic [2:0] RegLevelThree = 3'd5;
    localparam logic [2:0] RegHysteresis = 3'd6;

    // Action codes.
    localparam logic [1:0] ActNone = 2'd0;
    localparam logic [1:0] ActUp   = 2'd1;
    localparam logic [1:0] ActDown = 2'd2;

    typedef struct packed {
        logic [MaskW-1:0] online_mask;
        logic [LoadW-1:0] load_core0;
        logic [LoadW-1:0] load_core1;
        logic [LoadW-1:0] load_core2;
        logic [LoadW-1:0] load_core3;
    } in_word_t;

    typedef struct packed {
        logic [EmaW-1:0]   smoothed_load;
        logic [CountW-1:0] wanted_cores;
        logic [1:0]        action;
        logic [1:0]        target_core;
        logic              target_valid;
    } out_word_t;

    typedef struct packed {
        logic              enable;
        logic [CountW-1:0] min_cores;
        logic [CountW-1:0] max_cores;
        logic [LimitW-1:0] level_one_limit;
        logic [LimitW-1:0] level_two_limit;
        logic [LimitW-1:0] level_three_limit;
        logic [HystW-1:0]  hysteresis_eighths;
    } cfg_t;

endpackage

[hdl/cchg_cfg_regs.sv]
// APB configuration registers of the core-count hotplug governor.
module cchg_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cchg_pkg::AddrW-1:0]   paddr,
    input  logic [cchg_pkg::DataW-1:0]   pwdata,
    output logic [cchg_pkg::DataW-1:0]   prdata,
    output logic                         pready,
    output cchg_pkg::cfg_t               cfg
);

    cchg_pkg::cfg_t cfg_reg;
    cchg_pkg::cfg_t cfg_next;
    logic [2:0]     reg_index;
    logic           write_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[cchg_pkg::AddrW-1:2];
    assign write_en  = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    // Write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (write_en) begin
            unique case (reg_index)
                cchg_pkg::RegEnable:     cfg_next.enable = pwdata[0];
                cchg_pkg::RegMinCores:   cfg_next.min_cores = pwdata[cchg_pkg::CountW-1:0];
                cchg_pkg::RegMaxCores:   cfg_next.max_cores = pwdata[cchg_pkg::CountW-1:0];
                cchg_pkg::RegLevelOne:   cfg_next.level_one_limit = pwdata[cchg_pkg::LimitW-1:0];
                cchg_pkg::RegLevelTwo:   cfg_next.level_two_limit = pwdata[cchg_pkg::LimitW-1:0];
                cchg_pkg::RegLevelThree: begin
                    cfg_next.level_three_limit = pwdata[cchg_pkg::LimitW-1:0];
                end
                cchg_pkg::RegHysteresis: begin
                    cfg_next.hysteresis_eighths = pwdata[cchg_pkg::HystW-1:0];
                end
                default: ;
            endcase
        end
    end

    // Register state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable             <= 1'b1;
            cfg_reg.min_cores          <= cchg_pkg::MinCoresReset;
            cfg_reg.max_cores          <= cchg_pkg::MaxCoresReset;
            cfg_reg.level_one_limit    <= cchg_pkg::LevelOneReset;
            cfg_reg.level_two_limit    <= cchg_pkg::LevelTwoReset;
            cfg_reg.level_three_limit  <= cchg_pkg::LevelThreeReset;
            cfg_reg.hysteresis_eighths <= cchg_pkg::HystReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        unique case (reg_index)
            cchg_pkg::RegEnable:     prdata = cchg_pkg::DataW'(cfg_reg.enable);
            cchg_pkg::RegMinCores:   prdata = cchg_pkg::DataW'(cfg_reg.min_cores);
            cchg_pkg::RegMaxCores:   prdata = cchg_pkg::DataW'(cfg_reg.max_cores);
            cchg_pkg::RegLevelOne:   prdata = cchg_pkg::DataW'(cfg_reg.level_one_limit);
            cchg_pkg::RegLevelTwo:   prdata = cchg_pkg::DataW'(cfg_reg.level_two_limit);
            cchg_pkg::RegLevelThree: prdata = cchg_pkg::DataW'(cfg_reg.level_three_limit);
            cchg_pkg::RegHysteresis: prdata = cchg_pkg::DataW'(cfg_reg.hysteresis_eighths);
            default:                 prdata = '0;
        endcase
    end

endmodule

[hdl/cchg_eval.sv]
// Single-pass evaluation of one tick: load sum, average, wanted count, action and target core.
module cchg_eval #(
    parameter int CORE_COUNT = 4
) (
    input  cchg_pkg::in_word_t              in_word,
    input  cchg_pkg::cfg_t                  cfg,
    input  logic [cchg_pkg::EmaW-1:0]       ema_reg,
    input  logic [cchg_pkg::CountW-1:0]     last_wanted_reg,
    output cchg_pkg::out_word_t             result,
    output logic [cchg_pkg::EmaW-1:0]       ema_next,
    output logic [cchg_pkg::CountW-1:0]     last_wanted_next
);

    localparam int CoresSeen = (CORE_COUNT < 4) ? CORE_COUNT : 4;

    logic [cchg_pkg::LoadW-1:0]   loads [4];
    logic [cchg_pkg::LimitW-1:0]  limits [3];
    logic [cchg_pkg::EmaW-1:0]    load_sum;
    logic [cchg_pkg::CountW-1:0]  online;
    logic [28:0]                  keep_prod;
    logic [26:0]                  new_prod;
    logic [29:0]                  acc;
    logic [cchg_pkg::EmaW-1:0]    ema_new;
    logic [cchg_pkg::CountW-1:0]  wanted;
    logic [1:0]                   action;
    logic [1:0]                   target;
    logic                         target_ok;

    assign loads[0]  = in_word.load_core0;
    assign loads[1]  = in_word.load_core1;
    assign loads[2]  = in_word.load_core2;
    assign loads[3]  = in_word.load_core3;
    assign limits[0] = cfg.level_one_limit;
    assign limits[1] = cfg.level_two_limit;
    assign limits[2] = cfg.level_three_limit;

    // Sum the loads of online cores and count them.
    always_comb begin
        load_sum = '0;
        online   = '0;
        for (int i = 0; i < CoresSeen; i++) begin
            if (in_word.online_mask[i]) begin
                load_sum = load_sum + cchg_pkg::EmaW'(loads[i]);
                online   = online + 3'd1;
            end
        end
    end

    // Exponential average in Q11.
    assign keep_prod = 29'(ema_reg) * 29'(cchg_pkg::EmaKeep);
    assign new_prod  = 27'(load_sum) * 27'(cchg_pkg::EmaNew);
    assign acc       = 30'(keep_prod) + 30'(new_prod);
    assign ema_new   = acc[cchg_pkg::QShift +: cchg_pkg::EmaW];

    // Pick the lowest count whose threshold covers the average.
    always_comb begin
        logic [10:0] thr;
        logic        found;
        wanted = 3'd4;
        found  = 1'b0;
        thr    = '0;
        for (int w = 1; w < 4; w++) begin
            thr = 11'(limits[w-1]);
            if (last_wanted_reg <= 3'(w)) begin
                thr = thr + 11'(cfg.hysteresis_eighths);
            end
            if (!found && ({1'b0, ema_new} <= {thr, 8'd0})) begin
                wanted = 3'(w);
                found  = 1'b1;
            end
        end
    end

    // Decide between bringing a core up, taking one down or doing nothing.
    always_comb begin
        if (wanted < cfg.min_cores || wanted > cfg.max_cores) begin
            action = cchg_pkg::ActNone;
        end else if ((online > cfg.max_cores || wanted < online)
                     && online >= cfg.min_cores) begin
            action = cchg_pkg::ActDown;
        end else if ((online < cfg.min_cores || wanted > online)
                     && online <= cfg.max_cores) begin
            action = cchg_pkg::ActUp;
        end else begin
            action = cchg_pkg::ActNone;
        end
    end

    // Name the core: lowest offline one to add, least-loaded non-boot one to remove.
    always_comb begin
        logic [cchg_pkg::LoadW-1:0] best;
        best      = '0;
        target    = '0;
        target_ok = 1'b0;
        case (action)
            cchg_pkg::ActUp: begin
                for (int i = 0; i < CoresSeen; i++) begin
                    if (!target_ok && !in_word.online_mask[i]) begin
                        target    = 2'(i);
                        target_ok = 1'b1;
                    end
                end
            end
            cchg_pkg::ActDown: begin
                for (int i = 1; i < CoresSeen; i++) begin
                    if (in_word.online_mask[i] && (!target_ok || loads[i] < best)) begin
                        best      = loads[i];
                        target    = 2'(i);
                        target_ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // A disabled governor reports held state and no action.
    always_comb begin
        if (cfg.enable) begin
            result.smoothed_load = ema_new;
            result.wanted_cores  = wanted;
            result.action        = action;
            result.target_core   = target;
            result.target_valid  = target_ok;
            ema_next             = ema_new;
            last_wanted_next     = wanted;
        end else begin
            result.smoothed_load = ema_reg;
            result.wanted_cores  = last_wanted_reg;
            result.action        = cchg_pkg::ActNone;
            result.target_core   = '0;
            result.target_valid  = 1'b0;
            ema_next             = ema_reg;
            last_wanted_next     = last_wanted_reg;
        end
    end

endmodule

[hdl/core_count_hotplug_governor.sv]
// Top level of the core-count hotplug governor: input register, evaluation, result register.
//
// One word on s_data per sample tick carries the online-core mask and the four
// per-core Q11 load averages. One result word per tick leaves on m_data with the
// smoothed load, the wanted core count, the action and the core it names.
// Configuration goes through the APB port (registers at 4-byte strides, pready
// tied high); the user must change it only while no tick is in flight, as the block
// itself does not enforce this. A word accepted on s_data lands in the input
// register, is evaluated from there, and is taken by the result register, which
// drives m_data; low m_ready can hold it in the input register. Throughput is one
// word per cycle while m_ready stays high; the loop through the smoothed-load and
// last-choice registers closes through the combinational evaluation.
// When m_ready is low the result register holds its word, the input register still
// fills, and s_ready drops only once both are occupied.
// Reset clears the smoothed load and the last choice to zero, empties both
// registers, and restores the configuration registers to their default values.
module core_count_hotplug_governor #(
    parameter int CORE_COUNT = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cchg_pkg::in_word_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cchg_pkg::out_word_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cchg_pkg::AddrW-1:0]  paddr,
    input  logic [cchg_pkg::DataW-1:0]  pwdata,
    output logic [cchg_pkg::DataW-1:0]  prdata,
    output logic                        pready
);

    cchg_pkg::cfg_t                 cfg;
    logic                           in_valid_reg;
    cchg_pkg::in_word_t             in_data_reg;
    logic                           out_valid_reg;
    cchg_pkg::out_word_t            out_data_reg;
    logic [cchg_pkg::EmaW-1:0]      ema_reg;
    logic [cchg_pkg::EmaW-1:0]      ema_next;
    logic [cchg_pkg::CountW-1:0]    last_wanted_reg;
    logic [cchg_pkg::CountW-1:0]    last_wanted_next;
    cchg_pkg::out_word_t            result;
    logic                           advance;
    logic                           take_in;

    cchg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cchg_eval #(
        .CORE_COUNT (CORE_COUNT)
    ) u_eval (
        .in_word          (in_data_reg),
        .cfg              (cfg),
        .ema_reg          (ema_reg),
        .last_wanted_reg  (last_wanted_reg),
        .result           (result),
        .ema_next         (ema_next),
        .last_wanted_next (last_wanted_next)
    );

    // Handshake: the held word moves on whenever the result slot is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            ema_reg         <= '0;
            last_wanted_reg <= '0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                ema_reg         <= ema_next;
                last_wanted_reg <= last_wanted_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // A disabled tick reports no action and leaves the average alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !cfg.enable |=> m_data.action == cchg_pkg::ActNone
                                   && !m_data.target_valid && $stable(ema_reg))
        else $error("disabled tick changed state or reported an action");

    // An enabled tick always wants between one and four cores.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cfg.enable |=> m_data.wanted_cores >= 3'd1 && m_data.wanted_cores <= 3'd4
                                  && last_wanted_reg == m_data.wanted_cores)
        else $error("wanted core count out of range or not recorded");

    // A named target only comes with an action.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.target_valid |-> m_data.action != cchg_pkg::ActNone)
        else $error("target named without an action");

    // Core 0 is never taken down.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == cchg_pkg::ActDown && m_data.target_valid
            |-> m_data.target_core != 2'd0)
        else $error("boot core chosen for removal");

    // The reported smoothed load is the state that the tick left behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_data.smoothed_load == ema_reg)
        else $error("reported load differs from stored average");

endmodule
